/* hw/rtl/jpq_pkg.sv */
// ----------------------------------------------------------------------------
// jpq_pkg
// Shared types and constants for the job priority queue.
// ----------------------------------------------------------------------------
package jpq_pkg;

    localparam int QueueDepth = 16;
    localparam int MaxResults = 16;
    localparam int PosW = $clog2(QueueDepth);
    localparam int OccW = $clog2(QueueDepth + 1);
    localparam int ResCntW = $clog2(MaxResults + 1);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_POP = 3'd1;
    localparam logic [2:0] CMD_USER = 3'd2;
    localparam logic [2:0] CMD_CAP = 3'd3;
    localparam logic [2:0] CMD_ALL = 3'd4;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ENTRY = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic signed [15:0] prio;
        logic [23:0] run_time;
        logic [15:0] mem_amount;
        logic [7:0] gpus;
        logic [7:0] cpus;
        logic [15:0] user_id;
        logic [15:0] job_id;
    } job_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_SHIFT = 5'b00100,
        S_EMIT = 5'b01000,
        S_WAIT = 5'b10000
    } state_t;

endpackage

/* hw/rtl/job_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// job_priority_queue_top
// Stable priority queue of job records with add, pop and list commands.
// ----------------------------------------------------------------------------
// Usage: one command word enters on s_axis (tdata = command, job_id, user_id,
// cpus, gpus, mem_amount, run_time, prio from bit 0 up). Results leave on
// m_axis; tuser carries the status, tlast marks the final result of a command.
// One item is handled at a time; s_axis_tready is low while a command runs.
// One slot is read per cycle through a single compare unit, except while a
// list walk waits on the output. After the accept, an add scans for its slot,
// then shifts each entry behind it back one place; a pop returns the head and
// shifts the rest forward; a list walks the occupied slots. A list hit is held
// in a pending register until the next hit or the end of the walk decides its
// tlast, so the final word can carry tlast. An add to a full queue or a pop of
// an empty one answers with a single status word.
// A result sits in the output register until taken; a list walk halts while
// a result waits there and m_axis_tready is low, so nothing is lost. Reset
// empties the queue; slots are not cleared, only the occupancy count.
// ----------------------------------------------------------------------------
module job_priority_queue_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command, job_id, user_id, cpus, gpus, mem_amount, run_time, prio
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_job_id, out_user_id, out_cpus, out_gpus, out_mem_amount,
    // out_run_time, out_prio
    output logic [103:0] m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int PW = jpq_pkg::PosW;
    localparam int OW = jpq_pkg::OccW;

    jpq_pkg::job_t slots [jpq_pkg::QueueDepth];

    jpq_pkg::state_t state_reg;
    logic [OW-1:0] occ_reg;
    logic [OW-1:0] idx_reg;
    logic [OW-1:0] pos_reg;
    logic [2:0] cmd_reg;
    jpq_pkg::job_t key_reg;
    logic [jpq_pkg::ResCntW-1:0] nres_reg;
    logic out_valid_reg;
    logic [1:0] out_status_reg;
    jpq_pkg::job_t out_job_reg;
    logic out_last_reg;
    logic pend_valid_reg;
    jpq_pkg::job_t pend_job_reg;

    jpq_pkg::job_t cur;
    logic hit;
    logic cur_ge;
    logic s_fire;
    logic out_free;
    logic walk_end;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == jpq_pkg::S_IDLE) && !out_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cur = slots[idx_reg[PW-1:0]];
    assign cur_ge = key_reg.prio <= cur.prio;

    always_comb begin
        case (cmd_reg)
            jpq_pkg::CMD_USER: hit = cur.user_id == key_reg.user_id;
            jpq_pkg::CMD_CAP: hit = (cur.cpus <= key_reg.cpus) && (cur.gpus <= key_reg.gpus)
                && (cur.mem_amount <= key_reg.mem_amount)
                && (cur.run_time <= key_reg.run_time);
            default: hit = 1'b1;
        endcase
    end

    assign walk_end = (idx_reg >= occ_reg) ||
        (nres_reg == jpq_pkg::ResCntW'(jpq_pkg::MaxResults));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jpq_pkg::S_IDLE;
            occ_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            idx_reg <= '0;
            nres_reg <= '0;
        end else begin
            case (state_reg)
                jpq_pkg::S_IDLE: begin
                    if (s_fire) begin
                        cmd_reg <= s_axis_tdata[2:0];
                        key_reg <= jpq_pkg::job_t'(s_axis_tdata[106:3]);
                        idx_reg <= '0;
                        nres_reg <= '0;
                        pend_valid_reg <= 1'b0;
                        case (s_axis_tdata[2:0])
                            jpq_pkg::CMD_ADD, jpq_pkg::CMD_POP, jpq_pkg::CMD_USER,
                            jpq_pkg::CMD_CAP, jpq_pkg::CMD_ALL:
                                state_reg <= jpq_pkg::S_SCAN;
                            default: state_reg <= jpq_pkg::S_IDLE;
                        endcase
                    end
                end
                jpq_pkg::S_SCAN: begin
                    if (cmd_reg == jpq_pkg::CMD_ADD) begin
                        if (occ_reg == OW'(jpq_pkg::QueueDepth)) begin
                            out_valid_reg <= 1'b1;
                            out_status_reg <= jpq_pkg::ST_FULL;
                            out_job_reg <= '0;
                            out_last_reg <= 1'b1;
                            state_reg <= jpq_pkg::S_WAIT;
                        end else if (idx_reg < occ_reg && cur_ge) begin
                            idx_reg <= idx_reg + 1'b1;
                        end else begin
                            pos_reg <= idx_reg;
                            idx_reg <= occ_reg;
                            state_reg <= jpq_pkg::S_SHIFT;
                        end
                    end else if (cmd_reg == jpq_pkg::CMD_POP) begin
                        out_valid_reg <= 1'b1;
                        out_last_reg <= 1'b1;
                        if (occ_reg == '0) begin
                            out_status_reg <= jpq_pkg::ST_EMPTY;
                            out_job_reg <= '0;
                            state_reg <= jpq_pkg::S_WAIT;
                        end else begin
                            out_status_reg <= jpq_pkg::ST_ENTRY;
                            out_job_reg <= cur;
                            idx_reg <= '0;
                            state_reg <= jpq_pkg::S_SHIFT;
                        end
                    end else begin
                        state_reg <= jpq_pkg::S_EMIT;
                    end
                end
                jpq_pkg::S_SHIFT: begin
                    if (cmd_reg == jpq_pkg::CMD_ADD) begin
                        if (idx_reg == pos_reg) begin
                            slots[idx_reg[PW-1:0]] <= key_reg;
                            occ_reg <= occ_reg + 1'b1;
                            out_valid_reg <= 1'b1;
                            out_status_reg <= jpq_pkg::ST_ADDED;
                            out_job_reg <= '0;
                            out_last_reg <= 1'b1;
                            state_reg <= jpq_pkg::S_WAIT;
                        end else begin
                            slots[idx_reg[PW-1:0]] <= slots[PW'(idx_reg - 1'b1)];
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end else begin
                        if (m_axis_tready) out_valid_reg <= 1'b0;
                        if (idx_reg + 1'b1 >= occ_reg) begin
                            occ_reg <= occ_reg - 1'b1;
                            state_reg <= jpq_pkg::S_WAIT;
                        end else begin
                            slots[idx_reg[PW-1:0]] <= slots[PW'(idx_reg + 1'b1)];
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                jpq_pkg::S_EMIT: begin
                    // a hit waits in the pending register until the next hit
                    // or the end of the walk decides its tlast
                    if (out_free) begin
                        if (walk_end) begin
                            out_valid_reg <= 1'b1;
                            out_last_reg <= 1'b1;
                            if (pend_valid_reg) begin
                                out_status_reg <= jpq_pkg::ST_ENTRY;
                                out_job_reg <= pend_job_reg;
                            end else begin
                                out_status_reg <= jpq_pkg::ST_EMPTY;
                                out_job_reg <= '0;
                            end
                            pend_valid_reg <= 1'b0;
                            state_reg <= jpq_pkg::S_WAIT;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                            if (hit) begin
                                pend_valid_reg <= 1'b1;
                                pend_job_reg <= cur;
                                nres_reg <= nres_reg + 1'b1;
                            end
                            if (hit && pend_valid_reg) begin
                                out_valid_reg <= 1'b1;
                                out_status_reg <= jpq_pkg::ST_ENTRY;
                                out_job_reg <= pend_job_reg;
                                out_last_reg <= 1'b0;
                            end else begin
                                out_valid_reg <= 1'b0;
                            end
                        end
                    end
                end
                jpq_pkg::S_WAIT: begin
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_reg <= 1'b0;
                        state_reg <= jpq_pkg::S_IDLE;
                    end
                end
                default: state_reg <= jpq_pkg::S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = out_status_reg;
    assign m_axis_tdata = {out_job_reg.prio, out_job_reg.run_time, out_job_reg.mem_amount,
        out_job_reg.gpus, out_job_reg.cpus, out_job_reg.user_id, out_job_reg.job_id};

    assert property (@(posedge aclk) disable iff (!aresetn) occ_reg <= OW'(jpq_pkg::QueueDepth))
        else $error("occupancy overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> state_reg == jpq_pkg::S_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != jpq_pkg::ST_ENTRY) |-> m_axis_tlast)
        else $error("status word without last");

endmodule
